// File: rtl/core/lpc_pkg.sv
// Shared constants, types and arithmetic helpers of the LED palette phase cycler.
package lpc_pkg;

   localparam int LEDS       = 16;
   localparam int INTERVAL   = 64;
   localparam int MAX_COLORS = 6;

   localparam int PAL_DEPTH  = 6;
   localparam int NUM_CH     = 3;

   localparam int OP_W       = 2;
   localparam int AMT_W      = 16;
   localparam int LED_W      = 5;
   localparam int PV_W       = 9;
   localparam int CH_W       = 8;
   localparam int RGB_W      = 3 * CH_W;
   localparam int CC_W       = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = RGB_W;

   localparam int PH_W       = $clog2(INTERVAL * MAX_COLORS + 1);
   localparam int SUM_W      = PH_W + 1;
   localparam int LED_AW     = (LEDS > 1) ? $clog2(LEDS) : 1;
   localparam int LED_CW     = $clog2(LEDS + 1);
   localparam int PAL_AW     = $clog2(PAL_DEPTH);
   localparam int FR_W       = $clog2(INTERVAL);
   localparam int WT_W       = $clog2(INTERVAL + 1);
   localparam int MIX_W      = CH_W + WT_W;
   localparam int RED_STEPS  = $clog2(2 * MAX_COLORS);
   localparam int MOD_CW     = $clog2(AMT_W);

   localparam logic [CC_W-1:0] CC_RESET = CC_W'(6);

   localparam logic [CSR_IDX_W-1:0] REG_COLOR_COUNT   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_PALETTE_FIRST = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_PALETTE_LAST  = CSR_IDX_W'(6);

   typedef enum logic [OP_W-1:0] {
      OP_ADVANCE = 2'd0,
      OP_READ    = 2'd1,
      OP_WRITE   = 2'd2,
      OP_CLEAR   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WR_MOD,
      ST_ADV_MOD,
      ST_ADV,
      ST_RD_PH,
      ST_RD_PA,
      ST_RD_PB,
      ST_RD_OUT
   } state_type;

   typedef struct packed {
      logic             start;
      logic [AMT_W-1:0] dividend;
      logic [PH_W-1:0]  divisor;
   } mod_req_type;

   typedef struct packed {
      logic            done;
      logic [PH_W-1:0] remainder;
   } mod_rsp_type;

   typedef struct packed {
      logic [PAL_AW-1:0] entry;
      logic [FR_W-1:0]   frac;
   } pos_type;

   function automatic logic [CC_W-1:0] colours_used(logic [CC_W-1:0] cc);
      logic [CC_W-1:0] cu;
      cu = cc;
      if (cu == '0) begin
         cu = CC_W'(1);
      end else if (cu > CC_W'(MAX_COLORS)) begin
         cu = CC_W'(MAX_COLORS);
      end
      return cu;
   endfunction

   function automatic logic [PH_W-1:0] period_of(logic [CC_W-1:0] cc);
      return PH_W'(colours_used(cc) * INTERVAL);
   endfunction

   // Reduces a value below 2^RED_STEPS periods by shifted compare and subtract.
   function automatic logic [PH_W-1:0] reduce_phase(logic [SUM_W-1:0] x, logic [PH_W-1:0] p);
      logic [SUM_W+RED_STEPS-1:0] r;
      logic [SUM_W+RED_STEPS-1:0] d;
      r = (SUM_W+RED_STEPS)'(x);
      for (int k = RED_STEPS - 1; k >= 0; k--) begin
         d = (SUM_W+RED_STEPS)'(p) << k;
         if (r >= d) begin
            r = r - d;
         end
      end
      return r[PH_W-1:0];
   endfunction

   function automatic pos_type split_phase(logic [PH_W-1:0] ph);
      pos_type         pos;
      logic [PH_W-1:0] base;
      pos.entry = '0;
      base      = '0;
      for (int k = 1; k < MAX_COLORS; k++) begin
         if (ph >= PH_W'(k * INTERVAL)) begin
            pos.entry = PAL_AW'(k);
            base      = PH_W'(k * INTERVAL);
         end
      end
      pos.frac = FR_W'(ph - base);
      return pos;
   endfunction

   function automatic logic [MIX_W-1:0] mix_channel(logic [CH_W-1:0] a, logic [CH_W-1:0] b,
                                                    logic [FR_W-1:0] f);
      logic [WT_W-1:0] wa;
      logic [WT_W-1:0] wb;
      wb = WT_W'(f);
      wa = WT_W'(INTERVAL) - wb;
      return (MIX_W'(a) * MIX_W'(wa)) + (MIX_W'(b) * MIX_W'(wb));
   endfunction

   // Truncating division by the interval; the quotient always fits one channel.
   function automatic logic [CH_W-1:0] div_interval(logic [MIX_W-1:0] x);
      return CH_W'(x / MIX_W'(INTERVAL));
   endfunction

endpackage

// File: rtl/core/lpc_if.sv
// Handshake interfaces for the request, response and register write channels.
interface lpc_req_if;
   import lpc_pkg::*;
   logic              valid;
   logic              ready;
   op_type            operation;
   logic [AMT_W-1:0]  amount;
   logic [LED_W-1:0]  led_index;
   logic [PV_W-1:0]   phase_value;
   modport source (output valid, operation, amount, led_index, phase_value, input ready);
   modport sink   (input valid, operation, amount, led_index, phase_value, output ready);
endinterface

interface lpc_rsp_if;
   import lpc_pkg::*;
   logic             valid;
   logic             ready;
   logic [CH_W-1:0]  red;
   logic [CH_W-1:0]  green;
   logic [CH_W-1:0]  blue;
   modport source (output valid, red, green, blue, input ready);
   modport sink   (input valid, red, green, blue, output ready);
endinterface

interface lpc_csr_if;
   import lpc_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/lpc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module lpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: rtl/core/lpc_mod.sv
// Bit-serial remainder unit: reduces a step count modulo the current period.
module lpc_mod (
   input  logic                 clock,
   input  logic                 reset,
   input  lpc_pkg::mod_req_type mod_req,
   output lpc_pkg::mod_rsp_type mod_rsp
);
   import lpc_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [MOD_CW-1:0] cnt_ff, cnt_in;
   logic [AMT_W-1:0]  dvd_ff, dvd_in;
   logic [PH_W-1:0]   dsr_ff, dsr_in;
   logic [PH_W-1:0]   rem_ff, rem_in;
   logic [PH_W:0]     trial;
   logic [PH_W:0]     diff;
   logic [PH_W-1:0]   rem_step;

   always_comb begin
      trial    = {rem_ff, dvd_ff[AMT_W-1]};
      diff     = trial - {1'b0, dsr_ff};
      rem_step = (trial >= {1'b0, dsr_ff}) ? diff[PH_W-1:0] : trial[PH_W-1:0];
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      priority if (mod_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = mod_req.dividend;
         dsr_in  = mod_req.divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = rem_step;
         dvd_in = dvd_ff << 1;
         cnt_in = cnt_ff + MOD_CW'(1);
         if (cnt_ff == MOD_CW'(AMT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign mod_rsp.done      = done_ff;
   assign mod_rsp.remainder = rem_ff;
endmodule

// File: rtl/core/led_palette_phase_cycler_core.sv
// Top level of the LED palette phase cycler: phase memory, palette memory and control.
//
//   Channel  Direction  Carries
//   req_bus  in         operation, amount, led_index, phase_value
//   rsp_bus  out        red, green, blue (one item per colour read)
//   csr_bus  in         index, data (colour count and palette writes)
//
// One item is handled at a time. Phase writes and advances wait on the serial
// remainder unit (one bit per cycle); an advance then rewrites every phase in turn
// through the single read port of the phase memory.
// Reset is synchronous; phases and palette entries read as zero until written.
// A finished colour waits in the output register while the next item is taken.
module led_palette_phase_cycler_core (
   input logic       clock,
   input logic       reset,
   lpc_req_if.sink   req_bus,
   lpc_rsp_if.source rsp_bus,
   lpc_csr_if.sink   csr_bus
);
   import lpc_pkg::*;

   state_type         state_ff, state_in;
   logic [CC_W-1:0]   color_count_ff;
   logic [PAL_DEPTH-1:0] pal_vld_ff;
   logic [LEDS-1:0]   ph_vld_ff, ph_vld_in;
   logic [LED_AW-1:0] led_ff, led_in;
   logic [LED_CW-1:0] rd_ptr_ff, rd_ptr_in;
   logic              adv_vld_ff, adv_vld_in;
   logic [LED_AW-1:0] adv_addr_ff, adv_addr_in;
   logic [PH_W-1:0]   am_ff, am_in;
   logic              ph_hit_ff, ph_hit_in;
   logic              pal_hit_ff, pal_hit_in;
   logic [PAL_AW-1:0] e_ff, e_in;
   logic [FR_W-1:0]   f_ff, f_in;
   logic [RGB_W-1:0]  ca_ff, ca_in;
   logic [MIX_W-1:0]  mix_ff [NUM_CH];
   logic [MIX_W-1:0]  mix_in [NUM_CH];
   logic              rsp_vld_ff, rsp_vld_in;
   logic [CH_W-1:0]   red_ff, red_in;
   logic [CH_W-1:0]   green_ff, green_in;
   logic [CH_W-1:0]   blue_ff, blue_in;

   logic              req_fire;
   logic              csr_fire;
   logic              led_ok;
   logic              out_free;
   logic [PH_W-1:0]   period;
   logic [CC_W-1:0]   cused;
   logic [PH_W-1:0]   ph_eff;
   logic [RGB_W-1:0]  pal_eff;
   pos_type           pos;
   logic [PAL_AW:0]   e_next;

   logic              ph_wr_en, ph_rd_en;
   logic [LED_AW-1:0] ph_wr_addr, ph_rd_addr;
   logic [PH_W-1:0]   ph_wr_data, ph_rd_data;
   logic              pal_wr_en, pal_rd_en;
   logic [PAL_AW-1:0] pal_wr_addr, pal_rd_addr;
   logic [RGB_W-1:0]  pal_rd_data;

   mod_req_type       mod_req;
   mod_rsp_type       mod_rsp;

   lpc_ram #(.WIDTH(PH_W), .DEPTH(LEDS)) u_phase_ram (
      .clock   (clock),
      .wr_en   (ph_wr_en),
      .wr_addr (ph_wr_addr),
      .wr_data (ph_wr_data),
      .rd_en   (ph_rd_en),
      .rd_addr (ph_rd_addr),
      .rd_data (ph_rd_data)
   );

   lpc_ram #(.WIDTH(RGB_W), .DEPTH(PAL_DEPTH)) u_palette_ram (
      .clock   (clock),
      .wr_en   (pal_wr_en),
      .wr_addr (pal_wr_addr),
      .wr_data (csr_bus.data),
      .rd_en   (pal_rd_en),
      .rd_addr (pal_rd_addr),
      .rd_data (pal_rd_data)
   );

   lpc_mod u_mod (
      .clock   (clock),
      .reset   (reset),
      .mod_req (mod_req),
      .mod_rsp (mod_rsp)
   );

   assign req_fire = req_bus.valid && req_bus.ready;
   assign csr_fire = csr_bus.valid && csr_bus.ready;
   assign led_ok   = (LED_W+1)'(req_bus.led_index) < (LED_W+1)'(LEDS);
   assign out_free = !rsp_vld_ff || rsp_bus.ready;
   assign period   = period_of(color_count_ff);
   assign cused    = colours_used(color_count_ff);
   assign ph_eff   = ph_hit_ff ? ph_rd_data : '0;
   assign pal_eff  = pal_hit_ff ? pal_rd_data : '0;
   assign pos      = split_phase(reduce_phase(SUM_W'(ph_eff), period));
   assign e_next   = (PAL_AW+1)'(e_ff) + (PAL_AW+1)'(1);

   assign csr_bus.ready = 1'b1;
   assign pal_wr_en     = csr_fire && (csr_bus.index >= REG_PALETTE_FIRST)
                          && (csr_bus.index <= REG_PALETTE_LAST);
   assign pal_wr_addr   = PAL_AW'(csr_bus.index - REG_PALETTE_FIRST);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_bus.operation)
                  OP_ADVANCE: state_in = ST_ADV_MOD;
                  OP_WRITE:   state_in = led_ok ? ST_WR_MOD : ST_IDLE;
                  OP_CLEAR:   state_in = ST_IDLE;
                  OP_READ:    state_in = led_ok ? ST_RD_PH : ST_RD_OUT;
               endcase
            end
         end
         ST_WR_MOD: begin
            if (mod_rsp.done) begin
               state_in = ST_IDLE;
            end
         end
         ST_ADV_MOD: begin
            if (mod_rsp.done) begin
               state_in = ST_ADV;
            end
         end
         ST_ADV: begin
            if (rd_ptr_ff == LED_CW'(LEDS)) begin
               state_in = ST_IDLE;
            end
         end
         ST_RD_PH:  state_in = ST_RD_PA;
         ST_RD_PA:  state_in = ST_RD_PB;
         ST_RD_PB:  state_in = ST_RD_OUT;
         ST_RD_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_comb begin
      req_bus.ready    = (state_ff == ST_IDLE);
      mod_req.start    = 1'b0;
      mod_req.dividend = req_bus.amount;
      mod_req.divisor  = period;
      ph_wr_en    = 1'b0;
      ph_wr_addr  = led_ff;
      ph_wr_data  = mod_rsp.remainder;
      ph_rd_en    = 1'b0;
      ph_rd_addr  = req_bus.led_index[LED_AW-1:0];
      pal_rd_en   = 1'b0;
      pal_rd_addr = pos.entry;
      ph_vld_in   = ph_vld_ff;
      led_in      = led_ff;
      rd_ptr_in   = rd_ptr_ff;
      adv_vld_in  = adv_vld_ff;
      adv_addr_in = adv_addr_ff;
      am_in       = am_ff;
      ph_hit_in   = ph_hit_ff;
      pal_hit_in  = pal_hit_ff;
      e_in        = e_ff;
      f_in        = f_ff;
      ca_in       = ca_ff;
      mix_in      = mix_ff;
      red_in      = red_ff;
      green_in    = green_ff;
      blue_in     = blue_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_bus.ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               led_in = req_bus.led_index[LED_AW-1:0];
               unique case (req_bus.operation)
                  OP_ADVANCE: begin
                     mod_req.start = 1'b1;
                     rd_ptr_in     = '0;
                  end
                  OP_WRITE: begin
                     mod_req.start    = led_ok;
                     mod_req.dividend = AMT_W'(req_bus.phase_value);
                  end
                  OP_CLEAR: begin
                     ph_vld_in = '0;
                  end
                  OP_READ: begin
                     if (led_ok) begin
                        ph_rd_en  = 1'b1;
                        ph_hit_in = ph_vld_ff[req_bus.led_index[LED_AW-1:0]];
                     end else begin
                        for (int c = 0; c < NUM_CH; c++) begin
                           mix_in[c] = '0;
                        end
                     end
                  end
               endcase
            end
         end
         ST_WR_MOD: begin
            if (mod_rsp.done) begin
               ph_wr_en          = 1'b1;
               ph_vld_in[led_ff] = 1'b1;
            end
         end
         ST_ADV_MOD: begin
            if (mod_rsp.done) begin
               am_in      = mod_rsp.remainder;
               adv_vld_in = 1'b0;
            end
         end
         ST_ADV: begin
            if (rd_ptr_ff < LED_CW'(LEDS)) begin
               ph_rd_en    = 1'b1;
               ph_rd_addr  = rd_ptr_ff[LED_AW-1:0];
               ph_hit_in   = ph_vld_ff[rd_ptr_ff[LED_AW-1:0]];
               adv_vld_in  = 1'b1;
               adv_addr_in = rd_ptr_ff[LED_AW-1:0];
               rd_ptr_in   = rd_ptr_ff + LED_CW'(1);
            end else begin
               adv_vld_in = 1'b0;
            end
            if (adv_vld_ff) begin
               ph_wr_en               = 1'b1;
               ph_wr_addr             = adv_addr_ff;
               ph_wr_data             = reduce_phase(SUM_W'(ph_eff) + SUM_W'(am_ff), period);
               ph_vld_in[adv_addr_ff] = 1'b1;
            end
         end
         ST_RD_PH: begin
            e_in        = pos.entry;
            f_in        = pos.frac;
            pal_rd_en   = 1'b1;
            pal_rd_addr = pos.entry;
            pal_hit_in  = pal_vld_ff[pos.entry];
         end
         ST_RD_PA: begin
            ca_in       = pal_eff;
            pal_rd_en   = 1'b1;
            pal_rd_addr = (e_next >= (PAL_AW+1)'(cused)) ? '0 : e_next[PAL_AW-1:0];
            pal_hit_in  = pal_vld_ff[pal_rd_addr];
         end
         ST_RD_PB: begin
            for (int c = 0; c < NUM_CH; c++) begin
               mix_in[c] = mix_channel(ca_ff[RGB_W-1-CH_W*c -: CH_W],
                                       pal_eff[RGB_W-1-CH_W*c -: CH_W], f_ff);
            end
         end
         ST_RD_OUT: begin
            if (out_free) begin
               red_in     = div_interval(mix_ff[0]);
               green_in   = div_interval(mix_ff[1]);
               blue_in    = div_interval(mix_ff[2]);
               rsp_vld_in = 1'b1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         color_count_ff <= CC_RESET;
         pal_vld_ff     <= '0;
         ph_vld_ff      <= '0;
         rd_ptr_ff      <= '0;
         adv_vld_ff     <= 1'b0;
         rsp_vld_ff     <= 1'b0;
      end else begin
         state_ff   <= state_in;
         ph_vld_ff  <= ph_vld_in;
         rd_ptr_ff  <= rd_ptr_in;
         adv_vld_ff <= adv_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         if (csr_fire && (csr_bus.index == REG_COLOR_COUNT)) begin
            color_count_ff <= csr_bus.data[CC_W-1:0];
         end
         if (pal_wr_en) begin
            pal_vld_ff[pal_wr_addr] <= 1'b1;
         end
      end
      led_ff      <= led_in;
      adv_addr_ff <= adv_addr_in;
      am_ff       <= am_in;
      ph_hit_ff   <= ph_hit_in;
      pal_hit_ff  <= pal_hit_in;
      e_ff        <= e_in;
      f_ff        <= f_in;
      ca_ff       <= ca_in;
      mix_ff      <= mix_in;
      red_ff      <= red_in;
      green_ff    <= green_in;
      blue_ff     <= blue_in;
   end

   assign rsp_bus.valid = rsp_vld_ff;
   assign rsp_bus.red   = red_ff;
   assign rsp_bus.green = green_ff;
   assign rsp_bus.blue  = blue_ff;
endmodule
